FILE: src/ipow_pkg.sv
// shared widths and codes for the integer power block
package ipow_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned HalfW = 32;

	typedef logic [WordW-1:0] word_t;
	typedef logic [HalfW-1:0] half_t;

	// width modes selected by the opcode
	localparam logic OP_WIDE   = 1'b0;
	localparam logic OP_NARROW = 1'b1;

	// which product the shared multiplier is building
	typedef enum logic {
		MUL_ACC,
		MUL_SQR
	} mul_sel_t;

	// partial product steps of one 64 x 64 low-half product
	typedef enum logic [1:0] {
		PART_LL,
		PART_LH,
		PART_HL
	} part_t;

	function automatic word_t sext_half(input half_t v);
		return {{HalfW{v[HalfW-1]}}, v};
	endfunction

endpackage

FILE: src/integer_power_square_multiply.sv
// integer power by square-and-multiply over one shared 32 x 32 multiplier
//
// input channel: in_valid / in_ready carry opcode, base and exponent as one
// word. opcode 0 raises a 64-bit base to the low 32 bits of the exponent,
// opcode 1 raises the low 32 bits of base to the full 64-bit exponent; the
// 32-bit power is sign-extended on result. output channel: out_valid /
// out_ready carry one result word per input word.
// each exponent bit costs a decision in ST_STEP, plus one multiply when the bit
// is set and one squaring while higher bits remain. a 64-bit product takes
// three passes through the multiplier (low x low, two cross terms), a 32-bit
// product one pass. a zero exponent or a negative one with a base other than
// 1 or -1 skips ST_MUL and goes straight to loading its result.
// in_ready is high only while the block is idle: one word is worked on at a
// time, and the next word can be taken the cycle after a result is loaded.
// the result register holds out_valid high until taken; a stalled receiver
// lets the next word run and holds it at its end until the register empties.
// reset (arst_n low) returns the block to idle with no result pending.
module integer_power_square_multiply (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                opcode,
	input  logic signed [63:0]  base,
	input  logic signed [63:0]  exponent,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  result
);
	import ipow_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t   state_q;
	part_t    part_q;
	mul_sel_t sel_q;
	logic     narrow_q;
	word_t    acc_q;
	word_t    b_q;
	word_t    mag_q;
	word_t    lo_q;
	half_t    cross_q;
	word_t    result_q;
	logic     out_valid_q;

	// operand decode at accept
	logic  in_narrow;
	word_t in_b;
	logic  in_neg;
	word_t in_mag;
	half_t exp_lo;
	logic  unit_base;
	logic  zero_out;

	// shared multiplier
	word_t x_op;
	half_t ma;
	half_t mb;
	word_t prod;
	half_t cross_sum;
	word_t wide_prod;
	word_t mag_next;

	// hand-over to the result register
	logic  load_result;
	word_t final_acc;

	always_comb begin
		in_narrow = (opcode == OP_NARROW);
		exp_lo    = exponent[HalfW-1:0];
		if (in_narrow) begin
			in_b   = sext_half(base[HalfW-1:0]);
			in_neg = exponent[WordW-1];
			in_mag = in_neg ? (word_t'(0) - word_t'(exponent)) : word_t'(exponent);
		end else begin
			in_b   = word_t'(base);
			in_neg = exp_lo[HalfW-1];
			in_mag = {{HalfW{1'b0}}, (in_neg ? (half_t'(0) - exp_lo) : exp_lo)};
		end
		unit_base = (in_b == word_t'(1)) || (in_b == {WordW{1'b1}});
		// negative exponent on a base other than +-1 truncates to zero
		zero_out  = in_neg && !unit_base && (in_mag != '0);
	end

	always_comb begin
		x_op = (sel_q == MUL_ACC) ? acc_q : b_q;
		case (part_q)
			PART_LL: begin
				ma = x_op[HalfW-1:0];
				mb = b_q[HalfW-1:0];
			end
			PART_LH: begin
				ma = x_op[HalfW-1:0];
				mb = b_q[WordW-1:HalfW];
			end
			PART_HL: begin
				ma = x_op[WordW-1:HalfW];
				mb = b_q[HalfW-1:0];
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod      = word_t'(ma) * word_t'(mb);
		cross_sum = cross_q + prod[HalfW-1:0];
		wide_prod = lo_q + {cross_sum, {HalfW{1'b0}}};
		mag_next  = mag_q >> 1;
	end

	assign final_acc   = narrow_q ? sext_half(acc_q[HalfW-1:0]) : acc_q;
	assign load_result = (((state_q == ST_STEP) && (mag_q == '0)) || (state_q == ST_DONE))
		&& (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			part_q      <= PART_LL;
			sel_q       <= MUL_ACC;
			out_valid_q <= 1'b0;
		end else begin
			if (load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						narrow_q <= in_narrow;
						b_q      <= in_b;
						acc_q    <= zero_out ? word_t'(0) : word_t'(1);
						mag_q    <= zero_out ? word_t'(0) : in_mag;
						state_q  <= ST_STEP;
					end
				end
				ST_STEP: begin
					part_q <= PART_LL;
					if (mag_q == '0) begin
						if (load_result) begin
							result_q <= final_acc;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_DONE;
						end
					end else if (mag_q[0]) begin
						// multiply in this bit, then clear it and come back
						sel_q   <= MUL_ACC;
						state_q <= ST_MUL;
					end else begin
						mag_q <= mag_next;
						if (mag_next != '0) begin
							sel_q   <= MUL_SQR;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					case (part_q)
						PART_LL: begin
							if (narrow_q) begin
								// only the low half matters in narrow mode
								if (sel_q == MUL_ACC) begin
									acc_q    <= prod;
									mag_q[0] <= 1'b0;
								end else begin
									b_q <= prod;
								end
								state_q <= ST_STEP;
							end else begin
								lo_q   <= prod;
								part_q <= PART_LH;
							end
						end
						PART_LH: begin
							cross_q <= prod[HalfW-1:0];
							part_q  <= PART_HL;
						end
						PART_HL: begin
							if (sel_q == MUL_ACC) begin
								acc_q    <= wide_prod;
								mag_q[0] <= 1'b0;
							end else begin
								b_q <= wide_prod;
							end
							part_q  <= PART_LL;
							state_q <= ST_STEP;
						end
						default: begin
							part_q  <= PART_LL;
							state_q <= ST_STEP;
						end
					endcase
				end
				ST_DONE: begin
					// finished word waits for the result register to empty
					if (load_result) begin
						result_q <= final_acc;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign result    = $signed(result_q);

endmodule
